### src/ftn_pkg.sv
// ftn_pkg: constants, widths and note-name tables for the frequency to note name unit.
// No dependencies; used by freq_to_note_name_unit.
`default_nettype none
package ftn_pkg;

  localparam int FREQ_FRAC_BITS  = 8;
  localparam int PITCH_FRAC_BITS = 8;

  localparam int FREQ_W  = 24;
  localparam int PITCH_W = 17;
  localparam int NOTE_W  = 9;
  localparam int IDX_W   = 4;
  localparam int OCT_W   = 4;
  localparam int CHAR_W  = 7;

  // log2 datapath: mantissa in [1,2) with 30 fraction bits, 16 result fraction bits
  localparam int LOG_FRAC = 16;
  localparam int M_FRAC   = 30;
  localparam int M_W      = M_FRAC + 1;
  localparam int EXP_W    = 5;
  localparam int SQ_W     = 2 * M_W;
  localparam int LQ_W     = EXP_W + LOG_FRAC;

  // pitch in Q16 before rounding
  localparam int PQ_W      = 26;
  localparam int PITCH_SH  = LOG_FRAC - PITCH_FRAC_BITS;
  // 12*log2(440) in Q16 minus 57 in Q16, plus the fraction bits of the input
  localparam int PQ_OFFSET = 12 * (FREQ_FRAC_BITS << LOG_FRAC) + 6905942 - 3735552;

  localparam logic signed [PQ_W-1:0] PITCH_LO = -(PQ_W'(1) <<< (PITCH_W - 1));
  localparam logic signed [PQ_W-1:0] PITCH_HI = (PQ_W'(1) <<< (PITCH_W - 1)) - PQ_W'(1);

  localparam int V_W      = PITCH_W + 1;
  localparam int NMAG_W   = V_W - PITCH_FRAC_BITS;
  localparam int NOTE_MAX = (1 << (NOTE_W - 1)) - 1;

  // n/12 as (n*171) >> 11, exact for 0..255
  localparam int DIV12_MUL = 171;
  localparam int DIV12_SH  = 11;
  localparam int DIV12_PW  = 16;
  localparam int Q_W       = 5;
  localparam int OCT_MAX   = (1 << OCT_W) - 1;

  // stages from accept to result strobe: input, normalize, squarings, five arithmetic stages
  localparam int LATENCY = LOG_FRAC + 7;

  localparam logic [CHAR_W-1:0] CH_A     = 7'h41;
  localparam logic [CHAR_W-1:0] CH_B     = 7'h42;
  localparam logic [CHAR_W-1:0] CH_C     = 7'h43;
  localparam logic [CHAR_W-1:0] CH_D     = 7'h44;
  localparam logic [CHAR_W-1:0] CH_E     = 7'h45;
  localparam logic [CHAR_W-1:0] CH_F     = 7'h46;
  localparam logic [CHAR_W-1:0] CH_G     = 7'h47;
  localparam logic [CHAR_W-1:0] CH_SHARP = 7'h23;
  localparam logic [CHAR_W-1:0] CH_FLAT  = 7'h62;
  localparam logic [CHAR_W-1:0] CH_NONE  = 7'h00;

  function automatic logic [CHAR_W-1:0] note_letter(input logic [IDX_W-1:0] idx,
                                                     input logic flats);
    logic [CHAR_W-1:0] ch;
    ch = CH_NONE;
    unique case (idx)
      4'd0:    ch = CH_C;
      4'd1:    ch = flats ? CH_D : CH_C;
      4'd2:    ch = CH_D;
      4'd3:    ch = flats ? CH_E : CH_D;
      4'd4:    ch = CH_E;
      4'd5:    ch = CH_F;
      4'd6:    ch = flats ? CH_G : CH_F;
      4'd7:    ch = CH_G;
      4'd8:    ch = flats ? CH_A : CH_G;
      4'd9:    ch = CH_A;
      4'd10:   ch = flats ? CH_B : CH_A;
      4'd11:   ch = CH_B;
      default: ch = CH_NONE;
    endcase
    return ch;
  endfunction

  function automatic logic is_black_key(input logic [IDX_W-1:0] idx);
    logic blk;
    blk = 1'b0;
    unique case (idx)
      4'd1, 4'd3, 4'd6, 4'd8, 4'd10: blk = 1'b1;
      default:                        blk = 1'b0;
    endcase
    return blk;
  endfunction

endpackage
`default_nettype wire

### src/freq_to_note_name_unit.sv
// An accepted beat reaches its result strobe out_valid through the input and normalize registers,
// the 16-stage log2 squaring chain and stages A to E.
// Throughput: one beat per cycle once busy is low, no stall; the receiver cannot hold results off.
// Reset (rst_n low, synchronous): pipeline valid bits cleared, want_flats cleared to 0,
// busy high and cfg_ready low through reset and in the cycle after it.
// Depends on ftn_pkg.
`default_nettype none
module freq_to_note_name_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [ftn_pkg::FREQ_W-1:0]          in_freq_hz,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic                                cfg_want_flats,
  output logic                                     out_valid,
  output logic signed [ftn_pkg::PITCH_W-1:0]       out_pitch_fixed,
  output logic signed [ftn_pkg::NOTE_W-1:0]        out_note_number,
  output logic [ftn_pkg::IDX_W-1:0]                out_note_index,
  output logic [ftn_pkg::OCT_W-1:0]                out_octave,
  output logic [ftn_pkg::CHAR_W-1:0]               out_letter_char,
  output logic [ftn_pkg::CHAR_W-1:0]               out_accidental_char,
  output logic                                     out_invalid,
  output logic                                     out_below_range
);

  localparam int NSQ = ftn_pkg::LOG_FRAC;

  logic busy_r;
  logic want_flats_r;
  logic accept;

  assign busy      = busy_r;
  assign cfg_ready = !busy_r;
  assign accept    = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b1;
      want_flats_r <= 1'b0;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        want_flats_r <= cfg_want_flats;
      end
    end
  end

  // ---------------- input stage
  logic                        s0_vld_r;
  logic [ftn_pkg::FREQ_W-1:0]  s0_f_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s0_vld_r <= 1'b0;
    else        s0_vld_r <= accept;
  end

  always_ff @(posedge clk) begin
    if (accept) s0_f_r <= in_freq_hz;
  end

  // ---------------- normalize: leading one to bit 30
  logic [ftn_pkg::EXP_W-1:0]  norm_e;
  logic [ftn_pkg::M_W-1:0]    norm_m;

  always_comb begin
    norm_e = '0;
    for (int i = 0; i < ftn_pkg::FREQ_W; i++) begin
      if (s0_f_r[i]) norm_e = ftn_pkg::EXP_W'(i);
    end
    norm_m = ftn_pkg::M_W'(s0_f_r) << (ftn_pkg::EXP_W'(ftn_pkg::M_FRAC) - norm_e);
  end

  // stage k holds the mantissa after k squarings; stage 0 is the normalized value
  logic                              sq_vld_r  [NSQ+1];
  logic [ftn_pkg::M_W-1:0]           sq_m_r    [NSQ+1];
  logic [ftn_pkg::LOG_FRAC-1:0]      sq_frac_r [NSQ+1];
  logic [ftn_pkg::EXP_W-1:0]         sq_e_r    [NSQ+1];
  logic                              sq_inv_r  [NSQ+1];

  always_ff @(posedge clk) begin
    if (!rst_n) sq_vld_r[0] <= 1'b0;
    else        sq_vld_r[0] <= s0_vld_r;
  end

  always_ff @(posedge clk) begin
    sq_m_r[0]    <= norm_m;
    sq_frac_r[0] <= '0;
    sq_e_r[0]    <= norm_e;
    sq_inv_r[0]  <= (s0_f_r == '0);
  end

  for (genvar k = 0; k < NSQ; k++) begin : g_sq
    logic [ftn_pkg::SQ_W-1:0]  sq;
    logic [ftn_pkg::M_W:0]     sq_top;
    logic                      bit_out;
    logic [ftn_pkg::M_W-1:0]   m_nxt;

    always_comb begin
      sq      = sq_m_r[k] * sq_m_r[k];
      sq_top  = sq[ftn_pkg::SQ_W-1:ftn_pkg::M_FRAC];
      bit_out = sq_top[ftn_pkg::M_W];
      m_nxt   = bit_out ? sq_top[ftn_pkg::M_W:1] : sq_top[ftn_pkg::M_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) sq_vld_r[k+1] <= 1'b0;
      else        sq_vld_r[k+1] <= sq_vld_r[k];
    end

    always_ff @(posedge clk) begin
      sq_m_r[k+1]    <= m_nxt;
      sq_frac_r[k+1] <= {sq_frac_r[k][ftn_pkg::LOG_FRAC-2:0], bit_out};
      sq_e_r[k+1]    <= sq_e_r[k];
      sq_inv_r[k+1]  <= sq_inv_r[k];
    end
  end

  // ---------------- stage A: pitch in Q16
  logic                                a_vld_r, a_inv_r;
  logic signed [ftn_pkg::PQ_W-1:0]     a_pq_r;
  logic [ftn_pkg::LQ_W-1:0]            lq_u;
  logic [ftn_pkg::PQ_W-1:0]            x12;
  logic signed [ftn_pkg::PQ_W-1:0]     a_pq_nxt;

  always_comb begin
    lq_u     = {sq_e_r[NSQ], sq_frac_r[NSQ]};
    x12      = (ftn_pkg::PQ_W'(lq_u) << 3) + (ftn_pkg::PQ_W'(lq_u) << 2);
    a_pq_nxt = $signed(x12 - ftn_pkg::PQ_W'(ftn_pkg::PQ_OFFSET));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else        a_vld_r <= sq_vld_r[NSQ];
  end

  always_ff @(posedge clk) begin
    a_pq_r  <= a_pq_nxt;
    a_inv_r <= sq_inv_r[NSQ];
  end

  // ---------------- stage B: round to pitch units and saturate
  logic                                 b_vld_r, b_inv_r;
  logic signed [ftn_pkg::PITCH_W-1:0]   b_p_r;
  logic signed [ftn_pkg::PQ_W-1:0]      p_wide;
  logic signed [ftn_pkg::PITCH_W-1:0]   b_p_nxt;

  always_comb begin
    p_wide = (a_pq_r + $signed(ftn_pkg::PQ_W'(1) << (ftn_pkg::PITCH_SH - 1)))
             >>> ftn_pkg::PITCH_SH;
    if (p_wide < ftn_pkg::PITCH_LO)      b_p_nxt = ftn_pkg::PITCH_LO[ftn_pkg::PITCH_W-1:0];
    else if (p_wide > ftn_pkg::PITCH_HI) b_p_nxt = ftn_pkg::PITCH_HI[ftn_pkg::PITCH_W-1:0];
    else                                 b_p_nxt = p_wide[ftn_pkg::PITCH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) b_vld_r <= 1'b0;
    else        b_vld_r <= a_vld_r;
  end

  always_ff @(posedge clk) begin
    b_p_r   <= b_p_nxt;
    b_inv_r <= a_inv_r;
  end

  // ---------------- stage C: note number, half-up then toward zero
  logic                                 c_vld_r, c_inv_r, c_below_r;
  logic signed [ftn_pkg::PITCH_W-1:0]   c_p_r;
  logic signed [ftn_pkg::NOTE_W-1:0]    c_nn_r;
  logic [ftn_pkg::V_W-1:0]              v;
  logic [ftn_pkg::V_W-1:0]              v_mag;
  logic [ftn_pkg::NMAG_W-1:0]           n_mag;
  logic [ftn_pkg::NOTE_W-1:0]           n_sat;
  logic                                 v_neg;
  logic signed [ftn_pkg::NOTE_W-1:0]    c_nn_nxt;

  always_comb begin
    v     = {b_p_r[ftn_pkg::PITCH_W-1], b_p_r}
            + (ftn_pkg::V_W'(1) << (ftn_pkg::PITCH_FRAC_BITS - 1));
    v_neg = v[ftn_pkg::V_W-1];
    v_mag = v_neg ? (~v + ftn_pkg::V_W'(1)) : v;
    n_mag = v_mag[ftn_pkg::V_W-1:ftn_pkg::PITCH_FRAC_BITS];
    if (!v_neg && n_mag > ftn_pkg::NMAG_W'(ftn_pkg::NOTE_MAX)) begin
      n_sat = ftn_pkg::NOTE_W'(ftn_pkg::NOTE_MAX);
    end else if (v_neg && n_mag > ftn_pkg::NMAG_W'(ftn_pkg::NOTE_MAX + 1)) begin
      n_sat = ftn_pkg::NOTE_W'(ftn_pkg::NOTE_MAX + 1);
    end else begin
      n_sat = n_mag[ftn_pkg::NOTE_W-1:0];
    end
    c_nn_nxt = $signed(v_neg ? (~n_sat + ftn_pkg::NOTE_W'(1)) : n_sat);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) c_vld_r <= 1'b0;
    else        c_vld_r <= b_vld_r;
  end

  always_ff @(posedge clk) begin
    c_p_r     <= b_p_r;
    c_nn_r    <= c_nn_nxt;
    c_below_r <= v_neg && (n_mag != '0);
    c_inv_r   <= b_inv_r;
  end

  // ---------------- stage D: divide by 12 via reciprocal
  logic                                 d_vld_r, d_inv_r, d_below_r;
  logic signed [ftn_pkg::PITCH_W-1:0]   d_p_r;
  logic signed [ftn_pkg::NOTE_W-1:0]    d_nn_r;
  logic [ftn_pkg::Q_W-1:0]              d_q_r;
  logic [ftn_pkg::IDX_W-1:0]            d_idx_r;
  logic [ftn_pkg::DIV12_PW-1:0]         div_prod;
  logic [ftn_pkg::Q_W-1:0]              q_nxt;
  logic [ftn_pkg::NOTE_W-2:0]           n8;
  logic [ftn_pkg::NOTE_W-2:0]           rem8;

  always_comb begin
    n8       = c_nn_r[ftn_pkg::NOTE_W-2:0];
    div_prod = ftn_pkg::DIV12_PW'(n8) * ftn_pkg::DIV12_PW'(ftn_pkg::DIV12_MUL);
    q_nxt    = div_prod[ftn_pkg::DIV12_SH +: ftn_pkg::Q_W];
    rem8     = n8 - ((ftn_pkg::NOTE_W-1)'(q_nxt) << 3) - ((ftn_pkg::NOTE_W-1)'(q_nxt) << 2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) d_vld_r <= 1'b0;
    else        d_vld_r <= c_vld_r;
  end

  always_ff @(posedge clk) begin
    d_p_r     <= c_p_r;
    d_nn_r    <= c_nn_r;
    d_q_r     <= q_nxt;
    d_idx_r   <= rem8[ftn_pkg::IDX_W-1:0];
    d_below_r <= c_below_r;
    d_inv_r   <= c_inv_r;
  end

  // ---------------- stage E: name lookup and result beat
  logic                          named;
  logic [ftn_pkg::OCT_W-1:0]     oct_sat;

  always_comb begin
    named   = !d_inv_r && !d_below_r;
    oct_sat = (d_q_r > ftn_pkg::Q_W'(ftn_pkg::OCT_MAX)) ? ftn_pkg::OCT_W'(ftn_pkg::OCT_MAX)
                                                        : d_q_r[ftn_pkg::OCT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= d_vld_r;
  end

  always_ff @(posedge clk) begin
    out_pitch_fixed     <= d_inv_r ? '0 : d_p_r;
    out_note_number     <= d_inv_r ? '0 : d_nn_r;
    out_note_index      <= named ? d_idx_r : '0;
    out_octave          <= named ? oct_sat : '0;
    out_letter_char     <= named ? ftn_pkg::note_letter(d_idx_r, want_flats_r) : ftn_pkg::CH_NONE;
    out_accidental_char <= (named && ftn_pkg::is_black_key(d_idx_r)) ?
                           (want_flats_r ? ftn_pkg::CH_FLAT : ftn_pkg::CH_SHARP) :
                           ftn_pkg::CH_NONE;
    out_invalid         <= d_inv_r;
    out_below_range     <= !d_inv_r && d_below_r;
  end

  // ---------------- checks
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(ftn_pkg::LATENCY) out_valid)
    else $error("accepted beat did not produce a result at fixed latency");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_invalid && out_below_range))
    else $error("invalid and below_range both set");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_invalid && !out_below_range) |-> (out_note_index <= 4'd11))
    else $error("note index out of range");

  a_below_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_invalid) |-> (out_below_range == out_note_number[ftn_pkg::NOTE_W-1]))
    else $error("below_range disagrees with note number sign");

  a_below_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_below_range || out_invalid)) |->
      (out_letter_char == ftn_pkg::CH_NONE && out_accidental_char == ftn_pkg::CH_NONE))
    else $error("name codes set without a valid note");

endmodule
`default_nettype wire
